// ===== hw/rtl/vau_pkg.sv =====
// Shared types, opcodes and saturation helper for the vec4 arithmetic unit.
`timescale 1ns / 1ps

package vau_pkg;

	typedef logic signed [15:0] q88_t;
	typedef logic signed [16:0] q88x_t;
	typedef q88_t [3:0] vec4_t;
	typedef logic [3:0][63:0] mat_t;

	typedef enum logic [3:0] {
		OP_DOT     = 4'd0,
		OP_CROSS   = 4'd1,
		OP_ADD     = 4'd2,
		OP_SUB     = 4'd3,
		OP_SCALE   = 4'd4,
		OP_VECXMAT = 4'd5,
		OP_MATXVEC = 4'd6,
		OP_MAXABS  = 4'd7,
		OP_LERP    = 4'd8,
		OP_EQUAL   = 4'd9
	} opcode_t;

	// operands of one lane: sum of x[k]*y[k], shifted down by 8, plus bias
	typedef struct packed {
		q88x_t [3:0] x;
		q88_t  [3:0] y;
		q88_t        bias;
	} lane_ops_t;

	typedef lane_ops_t [3:0] lane_ops_arr_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef struct packed {
		q88_t value;
		logic clip;
	} sat_t;

	typedef struct packed {
		logic  saturated;
		logic  vectors_equal;
		q88_t  scalar_out;
		vec4_t r;
	} result_t;

	localparam q88_t ONE_Q88 = 16'sd256;
	localparam logic signed [27:0] SAT_MAX = 28'sd32767;
	localparam logic signed [27:0] SAT_MIN = -28'sd32768;

	function automatic sat_t sat16(input logic signed [27:0] v);
		sat_t res;
		if (v > SAT_MAX) begin
			res.value = 16'sh7fff;
			res.clip  = 1'b1;
		end else if (v < SAT_MIN) begin
			res.value = 16'sh8000;
			res.clip  = 1'b1;
		end else begin
			res.value = v[15:0];
			res.clip  = 1'b0;
		end
		return res;
	endfunction

	function automatic q88x_t ext17(input q88_t v);
		return {v[15], v};
	endfunction

endpackage

// ===== hw/rtl/vec4_arithmetic_unit.sv =====
// Top level of the four-component Q8.8 vector ALU: input stage, lanes, merge.
// Stages: input, product, lane sum/saturate and merge/output registers; m_axis_tvalid
// rises once an item reaches the output register.
// Throughput: one item per cycle while m_axis_tready is high; each of the four lanes owns
// four 17x16 multipliers, so even the 16-product matrix ops do not need to iterate.
// Reset: all stage valids clear, matrix rows return to the identity matrix.
`timescale 1ns / 1ps

module vec4_arithmetic_unit
	import vau_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation[3:0], a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in, 4'b0
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// r_x, r_y, r_z, r_w, scalar_out, vectors_equal, saturated, 6'b0
	output logic [87:0]  m_axis_tdata
);

	localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_0100;
	localparam logic [63:0] ROW1_RST = 64'h0000_0000_0100_0000;
	localparam logic [63:0] ROW2_RST = 64'h0000_0100_0000_0000;
	localparam logic [63:0] ROW3_RST = 64'h0100_0000_0000_0000;

	mat_t          mat_q;
	stage_en_t     en;
	logic          v_s1;
	logic          v_s2;
	logic          v_s3;
	logic          v_s4;
	opcode_t       op_s1;
	vec4_t         a_s1;
	vec4_t         b_s1;
	q88_t          scale_s1;
	lane_ops_arr_t ops;
	vec4_t         lane_r;
	logic [3:0]    lane_clip;
	result_t       result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= ROW0_RST;
			mat_q[1] <= ROW1_RST;
			mat_q[2] <= ROW2_RST;
			mat_q[3] <= ROW3_RST;
		end else if (cfg_write) begin
			mat_q[cfg_index] <= cfg_data;
		end
	end

	// each stage moves when the next one is empty or moving
	always_comb begin
		en.s4 = !v_s4 || m_axis_tready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_axis_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1    <= opcode_t'(s_axis_tdata[3:0]);
			a_s1     <= s_axis_tdata[67:4];
			b_s1     <= s_axis_tdata[131:68];
			scale_s1 <= s_axis_tdata[147:132];
		end
	end

	vau_opsel u_opsel (
		.op    (op_s1),
		.a     (a_s1),
		.b     (b_s1),
		.scale (scale_s1),
		.mat   (mat_q),
		.ops   (ops)
	);

	for (genvar j = 0; j < 4; j++) begin : g_lane
		vau_lane u_lane (
			.clk  (clk),
			.en   (en),
			.ops  (ops[j]),
			.r    (lane_r[j]),
			.clip (lane_clip[j])
		);
	end

	vau_merge u_merge (
		.clk       (clk),
		.en        (en),
		.op        (op_s1),
		.a         (a_s1),
		.b         (b_s1),
		.lane_r    (lane_r),
		.lane_clip (lane_clip),
		.result    (result)
	);

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {6'd0, result};

	a_ready_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1)
		else $error("input stalled while first stage empty");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en.s4) |=> m_axis_tvalid)
		else $error("item lost entering output register");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en.s3) |=> v_s2)
		else $error("product stage dropped a stalled item");

endmodule

// ===== hw/rtl/vau_opsel.sv =====
// Operand routing: maps the opcode onto the multiplier slots of each lane.
`timescale 1ns / 1ps

module vau_opsel
	import vau_pkg::*;
(
	input  opcode_t       op,
	input  vec4_t         a,
	input  vec4_t         b,
	input  q88_t          scale,
	input  mat_t          mat,
	output lane_ops_arr_t ops
);

	always_comb begin
		ops = '0;
		case (op)
			OP_DOT: begin
				for (int k = 0; k < 4; k++) begin
					ops[0].x[k] = ext17(a[k]);
					ops[0].y[k] = b[k];
				end
			end
			OP_CROSS: begin
				// lane j: a_p*b_q - a_q*b_p, w lane stays zero
				ops[0].x[0] = ext17(a[1]);
				ops[0].y[0] = b[2];
				ops[0].x[1] = -ext17(a[2]);
				ops[0].y[1] = b[1];
				ops[1].x[0] = ext17(a[2]);
				ops[1].y[0] = b[0];
				ops[1].x[1] = -ext17(a[0]);
				ops[1].y[1] = b[2];
				ops[2].x[0] = ext17(a[0]);
				ops[2].y[0] = b[1];
				ops[2].x[1] = -ext17(a[1]);
				ops[2].y[1] = b[0];
			end
			OP_ADD: begin
				// times one in Q8.8, the shift then undoes it exactly
				for (int j = 0; j < 4; j++) begin
					ops[j].x[0] = ext17(a[j]) + ext17(b[j]);
					ops[j].y[0] = ONE_Q88;
				end
			end
			OP_SUB: begin
				for (int j = 0; j < 4; j++) begin
					ops[j].x[0] = ext17(a[j]) - ext17(b[j]);
					ops[j].y[0] = ONE_Q88;
				end
			end
			OP_SCALE: begin
				for (int j = 0; j < 4; j++) begin
					ops[j].x[0] = ext17(a[j]);
					ops[j].y[0] = scale;
				end
			end
			OP_VECXMAT: begin
				for (int j = 0; j < 4; j++) begin
					for (int k = 0; k < 4; k++) begin
						ops[j].x[k] = ext17(a[k]);
						ops[j].y[k] = mat[k][16*j +: 16];
					end
				end
			end
			OP_MATXVEC: begin
				for (int j = 0; j < 4; j++) begin
					for (int k = 0; k < 4; k++) begin
						ops[j].x[k] = ext17(a[k]);
						ops[j].y[k] = mat[j][16*k +: 16];
					end
				end
			end
			OP_LERP: begin
				for (int j = 0; j < 4; j++) begin
					ops[j].x[0] = ext17(b[j]) - ext17(a[j]);
					ops[j].y[0] = scale;
					ops[j].bias = a[j];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/vau_lane.sv =====
// One arithmetic lane: four products, sum, rescale, bias add and saturation.
`timescale 1ns / 1ps

module vau_lane
	import vau_pkg::*;
(
	input  logic      clk,
	input  stage_en_t en,
	input  lane_ops_t ops,
	output q88_t      r,
	output logic      clip
);

	logic signed [32:0] prod_s2 [4];
	q88_t               bias_s2;
	logic signed [34:0] acc;
	logic signed [26:0] acc_shr;
	logic signed [27:0] pre_sat;
	sat_t               sat_res;
	q88_t               r_s3;
	logic               clip_s3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < 4; k++) begin
				prod_s2[k] <= $signed(ops.x[k]) * $signed(ops.y[k]);
			end
			bias_s2 <= ops.bias;
		end
	end

	always_comb begin
		acc = 35'(prod_s2[0]) + 35'(prod_s2[1]) + 35'(prod_s2[2]) + 35'(prod_s2[3]);
		// arithmetic shift: rounds toward minus infinity
		acc_shr = acc[34:8];
		pre_sat = 28'(acc_shr) + 28'(bias_s2);
		sat_res = sat16(pre_sat);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			r_s3    <= sat_res.value;
			clip_s3 <= sat_res.clip;
		end
	end

	assign r    = r_s3;
	assign clip = clip_s3;

endmodule

// ===== hw/rtl/vau_merge.sv =====
// Merge stage: max-abs and equality side paths, per-opcode result assembly.
`timescale 1ns / 1ps

module vau_merge
	import vau_pkg::*;
(
	input  logic       clk,
	input  stage_en_t  en,
	input  opcode_t    op,
	input  vec4_t      a,
	input  vec4_t      b,
	input  vec4_t      lane_r,
	input  logic [3:0] lane_clip,
	output result_t    result
);

	opcode_t     op_s2;
	opcode_t     op_s3;
	logic [16:0] mag_s2 [4];
	logic        eq_s2;
	logic        eq_s3;
	sat_t        maxabs_s3;
	logic [16:0] mag [4];
	logic [16:0] max01;
	logic [16:0] max23;
	logic [16:0] max_all;
	result_t     res_d;
	result_t     result_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mag[k] = a[k][15] ? 17'(-ext17(a[k])) : 17'(ext17(a[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			op_s2 <= op;
			eq_s2 <= (a == b);
			for (int k = 0; k < 4; k++) begin
				mag_s2[k] <= mag[k];
			end
		end
	end

	always_comb begin
		max01   = (mag_s2[1] > mag_s2[0]) ? mag_s2[1] : mag_s2[0];
		max23   = (mag_s2[3] > mag_s2[2]) ? mag_s2[3] : mag_s2[2];
		max_all = (max23 > max01) ? max23 : max01;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			op_s3     <= op_s2;
			eq_s3     <= eq_s2;
			maxabs_s3 <= sat16($signed({11'd0, max_all}));
		end
	end

	always_comb begin
		res_d = '0;
		case (op_s3)
			OP_DOT: begin
				res_d.scalar_out = lane_r[0];
				res_d.saturated  = lane_clip[0];
			end
			OP_CROSS: begin
				res_d.r[0]      = lane_r[0];
				res_d.r[1]      = lane_r[1];
				res_d.r[2]      = lane_r[2];
				res_d.saturated = |lane_clip[2:0];
			end
			OP_ADD, OP_SUB, OP_SCALE, OP_VECXMAT, OP_MATXVEC, OP_LERP: begin
				res_d.r         = lane_r;
				res_d.saturated = |lane_clip;
			end
			OP_MAXABS: begin
				res_d.scalar_out = maxabs_s3.value;
				res_d.saturated  = maxabs_s3.clip;
			end
			OP_EQUAL: begin
				res_d.vectors_equal = eq_s3;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			result_s4 <= res_d;
		end
	end

	assign result = result_s4;

endmodule
